/* hw/rtl/bffa_pkg.sv */
// shared types and constants of the bitmap first-fit allocator
// no dependencies
package bffa_pkg;

   localparam int WORD_BITS = 8;
   localparam int OFF_W     = 18;
   localparam int SIZE_W    = 11;
   localparam int ADDR_W    = 32;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0] run;
      logic              hit;
      logic [OFF_W-1:0]  start;
   } scan_type;

endpackage

/* hw/rtl/bffa_cell.sv */
// one word of the used map in the rotating chain
// depends on bffa_pkg
module bffa_cell #(
   parameter logic [7:0] RST_VAL = 8'h00
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic [bffa_pkg::WORD_BITS-1:0] d,
   output logic [bffa_pkg::WORD_BITS-1:0] q
);

   logic [bffa_pkg::WORD_BITS-1:0] word_ff;
   logic [bffa_pkg::WORD_BITS-1:0] word_in;

   assign word_in = shift_en ? d : word_ff;
   assign q       = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= RST_VAL;
      end else begin
         word_ff <= word_in;
      end
   end

endmodule

/* hw/rtl/bffa_scan.sv */
// run search and range mask over one word at the head of the chain
// depends on bffa_pkg
module bffa_scan (
   input  logic [bffa_pkg::WORD_BITS-1:0] word,
   input  logic [bffa_pkg::SIZE_W-1:0]    run_in,
   input  logic [bffa_pkg::SIZE_W-1:0]    size,
   input  logic [bffa_pkg::OFF_W-1:0]     base,
   input  logic [bffa_pkg::OFF_W-1:0]     rng_start,
   output bffa_pkg::scan_type             res,
   output logic [bffa_pkg::WORD_BITS-1:0] mask
);

   logic [bffa_pkg::OFF_W-1:0] rng_end;

   assign rng_end = rng_start + bffa_pkg::OFF_W'(size);

   always_comb begin
      logic [bffa_pkg::SIZE_W-1:0] run;
      logic [bffa_pkg::OFF_W-1:0]  idx;
      run       = run_in;
      res.hit   = 1'b0;
      res.start = '0;
      for (int j = 0; j < bffa_pkg::WORD_BITS; j++) begin
         idx = base + bffa_pkg::OFF_W'(j);
         if (word[j]) begin
            run = '0;
         end else if (run != '1) begin
            run = run + 1'b1;
         end
         if (!res.hit && run == size) begin
            res.hit   = 1'b1;
            res.start = idx + 1'b1 - bffa_pkg::OFF_W'(size);
         end
         mask[j] = (idx >= rng_start) && (idx < rng_end);
      end
      res.run = run;
   end

endmodule

/* hw/rtl/bitmap_first_fit_allocator_core.sv */
// bitmap first-fit allocator: top level with the rotating chain of map cells
// depends on bffa_pkg, bffa_cell, bffa_scan
//
// req channel: func (allocate or free), size and free address in one
// transaction; rsp channel returns the allocated address and a status.
// csr_we/csr_wdata write pool_base; the user must write it only while the
// block is idle, the block itself does not enforce this. The used map sits
// in a ring of NW = ceil(POOL_BYTES/8) 8-bit cells that rotates one word per
// cycle, in the scan and mark states only, past a single search/mask unit at
// the head. Allocate: one full rotation to find the first fitting run, a
// second one to set it. Free and a no-space miss: one rotation. Size zero
// and a bad free skip the rotation and go straight to the response state.
// One request is processed at a time; a new one is accepted while the
// previous response still waits in the output register.
// Reset clears the map (bits past the pool end read as used) and pool_base.
// When rsp_tready is low the response holds and the block stalls before
// loading the next one.
module bitmap_first_fit_allocator_core #(
   parameter int POOL_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_size[10:0], free_address[42:11], zero fill
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // alloc_address[31:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int NW = (POOL_BYTES + bffa_pkg::WORD_BITS - 1) / bffa_pkg::WORD_BITS;
   localparam int CW = $clog2(NW) + 1;
   localparam int WB = bffa_pkg::WORD_BITS;

   logic [WB-1:0] chain [NW];
   logic [WB-1:0] head_new;
   logic          shift_en;

   bffa_pkg::state_type state_ff, state_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [bffa_pkg::SIZE_W-1:0]    run_ff, run_in;
   logic                           found_ff, found_in;
   logic [bffa_pkg::OFF_W-1:0]     start_ff, start_in;
   logic [bffa_pkg::SIZE_W-1:0]    size_ff, size_in;
   logic                           func_ff, func_in;
   logic [31:0]                    base_ff;
   logic [31:0]                    raddr_ff, raddr_in;
   logic [1:0]                     rstat_ff, rstat_in;
   logic                           rvalid_ff, rvalid_in;
   logic [31:0]                    rsp_addr_ff, rsp_addr_in;
   logic [1:0]                     rsp_stat_ff, rsp_stat_in;

   bffa_pkg::scan_type             scan_res;
   logic [WB-1:0]                  mask;
   logic [bffa_pkg::OFF_W-1:0]     word_base;
   logic [31:0]                    free_off;
   logic [32:0]                    free_end;
   logic                           last_word;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      localparam logic [7:0] PAD = 8'hFF << ((POOL_BYTES - i * WB) >= WB ? WB :
                                             (POOL_BYTES - i * WB));
      bffa_cell #(.RST_VAL(PAD)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d        ((i == NW - 1) ? head_new : chain[(i + 1) % NW]),
         .q        (chain[i])
      );
   end

   assign word_base = bffa_pkg::OFF_W'(cnt_ff) << 3;
   assign last_word = (cnt_ff == CW'(NW - 1));

   bffa_scan u_scan (
      .word      (chain[0]),
      .run_in    (run_ff),
      .size      (size_ff),
      .base      (word_base),
      .rng_start (start_ff),
      .res       (scan_res),
      .mask      (mask)
   );

   assign free_off = req_tdata[42:11] - base_ff;
   assign free_end = {1'b0, free_off} + 33'(req_tdata[10:0]);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      run_in      = run_ff;
      found_in    = found_ff;
      start_in    = start_ff;
      size_in     = size_ff;
      func_in     = func_ff;
      raddr_in    = raddr_ff;
      rstat_in    = rstat_ff;
      rvalid_in   = rvalid_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_stat_in = rsp_stat_ff;
      shift_en    = 1'b0;
      head_new    = chain[0];
      req_tready  = (state_ff == bffa_pkg::S_IDLE);

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         bffa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               size_in  = req_tdata[10:0];
               func_in  = req_tuser;
               cnt_in   = '0;
               run_in   = '0;
               found_in = 1'b0;
               raddr_in = '0;
               rstat_in = bffa_pkg::ST_OK;
               if (req_tdata[10:0] == '0) begin
                  state_in = bffa_pkg::S_RESP;
               end else if (req_tuser == bffa_pkg::FUNC_FREE) begin
                  start_in = free_off[bffa_pkg::OFF_W-1:0];
                  if (free_end > 33'(POOL_BYTES)) begin
                     rstat_in = bffa_pkg::ST_BAD;
                     state_in = bffa_pkg::S_RESP;
                  end else begin
                     state_in = bffa_pkg::S_MARK;
                  end
               end else begin
                  state_in = bffa_pkg::S_SCAN;
               end
            end
         end
         bffa_pkg::S_SCAN: begin
            shift_en = 1'b1;
            run_in   = scan_res.run;
            if (!found_ff && scan_res.hit) begin
               found_in = 1'b1;
               start_in = scan_res.start;
            end
            cnt_in = cnt_ff + 1'b1;
            if (last_word) begin
               cnt_in = '0;
               if (found_ff || scan_res.hit) begin
                  state_in = bffa_pkg::S_MARK;
               end else begin
                  rstat_in = bffa_pkg::ST_NOSPACE;
                  state_in = bffa_pkg::S_RESP;
               end
            end
         end
         bffa_pkg::S_MARK: begin
            shift_en = 1'b1;
            head_new = (func_ff == bffa_pkg::FUNC_FREE) ? (chain[0] & ~mask)
                                                        : (chain[0] | mask);
            cnt_in   = cnt_ff + 1'b1;
            if (last_word) begin
               cnt_in = '0;
               if (func_ff == bffa_pkg::FUNC_ALLOC) begin
                  raddr_in = base_ff + 32'(start_ff);
               end
               state_in = bffa_pkg::S_RESP;
            end
         end
         bffa_pkg::S_RESP: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in   = 1'b1;
               rsp_addr_in = raddr_ff;
               rsp_stat_in = rstat_ff;
               state_in    = bffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bffa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bffa_pkg::S_IDLE;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
         base_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rvalid_ff <= rvalid_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff      <= run_in;
      found_ff    <= found_in;
      start_ff    <= start_in;
      size_ff     <= size_in;
      func_ff     <= func_in;
      raddr_ff    <= raddr_in;
      rstat_ff    <= rstat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_stat_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CW'(NW)) else $error("word counter out of range");

   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> (rsp_stat_ff <= bffa_pkg::ST_BAD)) else $error("bad status code");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && rsp_stat_ff != bffa_pkg::ST_OK) |-> (rsp_addr_ff == '0))
      else $error("address on failed request");

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bffa_pkg::S_IDLE) |-> (cnt_ff == '0))
      else $error("counter not cleared in idle");

endmodule
